@@ hw/rtl/tcs_pkg.sv @@
package tcs_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int MAX_STEPS         = 3;
   localparam int CUE_COUNT         = 17;
   localparam int ROM_STEPS         = 3;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_PLAY = 2'd1;
   localparam logic [1:0] ACT_STOP = 2'd2;

   localparam logic REG_ENABLED  = 1'b0;
   localparam logic REG_ATTACHED = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  cue;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        tone_on;
      logic [11:0] frequency_hz;
      logic [8:0]  tone_limit_ms;
      logic        playing;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_PLAY,
      OP_STOP,
      OP_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [4:0]  cue;
      logic [31:0] now_ms;
   } op_type;

   typedef struct packed {
      logic [11:0] freq;
      logic [8:0]  dur;
      logic [6:0]  gap;
   } step_type;

   typedef step_type [0:ROM_STEPS-1] row_type;

   function automatic logic [1:0] cue_steps(input logic [4:0] cue);
      logic [1:0] n;
      unique case (cue)
         5'd0, 5'd5, 5'd10, 5'd13, 5'd14, 5'd15:                    n = 2'd3;
         5'd1, 5'd6, 5'd9:                                          n = 2'd1;
         5'd2, 5'd3, 5'd4, 5'd7, 5'd8, 5'd11, 5'd12, 5'd16:          n = 2'd2;
         default:                                                   n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic step_type rom_step(input logic [4:0] cue, input logic [1:0] step);
      row_type  row;
      step_type s;
      unique case (cue)
         5'd0:  row = '{'{12'd1050, 9'd80, 7'd30}, '{12'd1450, 9'd80, 7'd30},
                       '{12'd1950, 9'd120, 7'd0}};
         5'd1:  row = '{'{12'd1850, 9'd45, 7'd0}, '{12'd0, 9'd0, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd2:  row = '{'{12'd900, 9'd100, 7'd45}, '{12'd1200, 9'd150, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd3:  row = '{'{12'd1250, 9'd100, 7'd45}, '{12'd1250, 9'd150, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd4:  row = '{'{12'd1200, 9'd100, 7'd45}, '{12'd1750, 9'd150, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd5:  row = '{'{12'd1000, 9'd80, 7'd35}, '{12'd1400, 9'd80, 7'd35},
                       '{12'd1900, 9'd140, 7'd0}};
         5'd6:  row = '{'{12'd1550, 9'd100, 7'd0}, '{12'd0, 9'd0, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd7:  row = '{'{12'd1200, 9'd100, 7'd45}, '{12'd1850, 9'd160, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd8:  row = '{'{12'd1500, 9'd100, 7'd45}, '{12'd950, 9'd160, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd9:  row = '{'{12'd750, 9'd160, 7'd0}, '{12'd0, 9'd0, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd10: row = '{'{12'd1250, 9'd150, 7'd50}, '{12'd1650, 9'd150, 7'd50},
                       '{12'd2150, 9'd300, 7'd0}};
         5'd11: row = '{'{12'd1800, 9'd140, 7'd60}, '{12'd1150, 9'd220, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd12: row = '{'{12'd360, 9'd160, 7'd70}, '{12'd360, 9'd200, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         5'd13: row = '{'{12'd1500, 9'd120, 7'd40}, '{12'd2000, 9'd160, 7'd40},
                       '{12'd2500, 9'd250, 7'd0}};
         5'd14: row = '{'{12'd430, 9'd160, 7'd60}, '{12'd330, 9'd200, 7'd60},
                       '{12'd430, 9'd280, 7'd0}};
         5'd15: row = '{'{12'd900, 9'd220, 7'd80}, '{12'd650, 9'd300, 7'd80},
                       '{12'd450, 9'd450, 7'd0}};
         5'd16: row = '{'{12'd800, 9'd100, 7'd45}, '{12'd1400, 9'd180, 7'd0},
                       '{12'd0, 9'd0, 7'd0}};
         default: row = '{'{12'd1050, 9'd80, 7'd30}, '{12'd1450, 9'd80, 7'd30},
                         '{12'd1950, 9'd120, 7'd0}};
      endcase
      unique case (step)
         2'd1:    s = row[1];
         2'd2:    s = row[2];
         default: s = row[0];
      endcase
      return s;
   endfunction

endpackage

@@ hw/rtl/tone_cue_sequencer.sv @@
// Buzzer cue sequencer. Requests enter through a queue-style port: a transaction
// is taken when req_push is high and req_full is low. Each request (tick, play
// cue, stop, carrying the current millisecond time) produces exactly one
// response, which waits on rsp_data while rsp_empty is low and is taken when
// rsp_pop is high.
// A taken request is classified into the front queue, then executed by the back
// stage into the response queue, where its response becomes visible on rsp_data.
// Throughput is one request per cycle while the response queue has room; execution
// is ROM lookups, a wrapping deadline compare and one add in the back stage.
// If the consumer stops popping, the two-entry response queue fills, the back
// stage holds, the two-entry request queue fills and req_full rises; nothing
// is dropped.
// Registers (csr_we/csr_index/csr_wdata): index 0 is enable (reset 1, clearing
// it stops the cue), index 1 is driver attached (reset 0). Write them while idle.
// Reset is synchronous and empties both queues and silences the buzzer.
module tone_cue_sequencer #(
   parameter int TIME_BITS = tcs_pkg::TIME_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tcs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tcs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic             csr_wdata
);
   import tcs_pkg::*;

   logic   op_valid;
   logic   op_pop;
   op_type op_data;

   tcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_pop   (op_pop)
   );

   tcs_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_pop    (op_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/tcs_front.sv @@
module tcs_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  tcs_pkg::req_type req_data,
   output logic            op_valid,
   output tcs_pkg::op_type op_data,
   input  logic            op_pop
);
   import tcs_pkg::*;

   op_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;
   op_type             classified;

   always_comb begin
      classified.cue    = req_data.cue;
      classified.now_ms = req_data.now_ms;
      unique case (req_data.action)
         ACT_TICK: classified.kind = OP_TICK;
         ACT_PLAY: classified.kind = OP_PLAY;
         ACT_STOP: classified.kind = OP_STOP;
         default:  classified.kind = OP_NONE;
      endcase
   end

   assign req_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign op_valid = (count_ff != '0);
   assign op_data  = queue_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ hw/rtl/tcs_back.sv @@
module tcs_back #(
   parameter int TIME_BITS = tcs_pkg::TIME_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic             csr_wdata,
   input  logic             op_valid,
   input  tcs_pkg::op_type  op_data,
   output logic             op_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tcs_pkg::rsp_type rsp_data
);
   import tcs_pkg::*;

   logic                 enabled_ff, attached_ff;
   logic                 active_ff, active_in;
   logic [4:0]           cue_ff, cue_in;
   logic [1:0]           step_ff, step_in;
   logic [1:0]           total_ff, total_in;
   logic                 sounding_ff, sounding_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;

   rsp_type              out_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    out_wr_ff, out_rd_ff;
   logic [QCNT_W-1:0]    out_count_ff, out_count_in;
   logic                 out_take;

   logic [63:0]          now_wide;
   logic [TIME_BITS-1:0] now_t, diff;
   logic                 reached;
   logic [2:0]           step_next;
   logic [8:0]           addend;
   logic                 load_dl, clear_all;
   step_type             cur, out_step;
   step_type             first_step, next_step;
   rsp_type              result;

   assign op_pop    = op_valid && (out_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_take  = rsp_pop && !rsp_empty;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_ff[out_rd_ff];

   assign now_wide  = {32'd0, op_data.now_ms};
   assign now_t     = now_wide[TIME_BITS-1:0];
   assign diff      = now_t - deadline_ff;
   // Wrapping compare: the deadline is reached once now - deadline is non-negative.
   assign reached   = !diff[TIME_BITS-1];
   assign cur       = rom_step(cue_ff, step_ff);
   assign step_next = {1'b0, step_ff} + 3'd1;
   assign first_step = rom_step(op_data.cue, 2'd0);
   assign next_step  = rom_step(cue_ff, step_next[1:0]);

   always_comb begin
      active_in   = active_ff;
      cue_in      = cue_ff;
      step_in     = step_ff;
      total_in    = total_ff;
      sounding_in = sounding_ff;
      addend      = '0;
      load_dl     = 1'b0;
      clear_all   = 1'b0;
      unique case (op_data.kind)
         OP_PLAY: begin
            if (attached_ff && enabled_ff) begin
               if (cue_steps(op_data.cue) != 2'd0) begin
                  active_in   = 1'b1;
                  cue_in      = op_data.cue;
                  step_in     = 2'd0;
                  total_in    = (32'(cue_steps(op_data.cue)) > MAX_STEPS) ?
                                2'(MAX_STEPS) : cue_steps(op_data.cue);
                  sounding_in = 1'b1;
                  addend      = first_step.dur;
                  load_dl     = 1'b1;
               end else begin
                  clear_all = 1'b1;
               end
            end
         end
         OP_STOP: begin
            clear_all = 1'b1;
         end
         OP_TICK: begin
            if (active_ff && reached) begin
               if (sounding_ff && (cur.gap != '0)) begin
                  sounding_in = 1'b0;
                  addend      = {2'b00, cur.gap};
                  load_dl     = 1'b1;
               end else if (step_next >= {1'b0, total_ff}) begin
                  clear_all = 1'b1;
               end else begin
                  step_in     = step_next[1:0];
                  sounding_in = 1'b1;
                  addend      = next_step.dur;
                  load_dl     = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (clear_all) begin
         active_in   = 1'b0;
         cue_in      = '0;
         step_in     = '0;
         total_in    = '0;
         sounding_in = 1'b0;
      end
      if (clear_all) begin
         deadline_in = '0;
      end else if (load_dl) begin
         deadline_in = now_t + TIME_BITS'(addend);
      end else begin
         deadline_in = deadline_ff;
      end
   end

   always_comb begin
      out_step             = rom_step(cue_in, step_in);
      result.tone_on       = sounding_in;
      result.frequency_hz  = sounding_in ? out_step.freq : '0;
      result.tone_limit_ms = sounding_in ? out_step.dur : '0;
      result.playing       = active_in;
      out_count_in         = out_count_ff + QCNT_W'(op_pop) - QCNT_W'(out_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         attached_ff  <= 1'b0;
         active_ff    <= 1'b0;
         cue_ff       <= '0;
         step_ff      <= '0;
         total_ff     <= '0;
         sounding_ff  <= 1'b0;
         deadline_ff  <= '0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_ENABLED) begin
               enabled_ff <= csr_wdata;
            end else begin
               attached_ff <= csr_wdata;
            end
         end
         // Clearing the enable also stops any cue in progress.
         if (csr_we && (csr_index == REG_ENABLED) && !csr_wdata) begin
            active_ff   <= 1'b0;
            cue_ff      <= '0;
            step_ff     <= '0;
            total_ff    <= '0;
            sounding_ff <= 1'b0;
            deadline_ff <= '0;
         end else if (op_pop) begin
            active_ff   <= active_in;
            cue_ff      <= cue_in;
            step_ff     <= step_in;
            total_ff    <= total_in;
            sounding_ff <= sounding_in;
            deadline_ff <= deadline_in;
         end
         if (op_pop) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_take) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (total_ff != 2'd0) && (step_ff < total_ff))
      else $error("active cue with inconsistent step count");

   a_sound_needs_active: assert property (@(posedge clock) disable iff (reset)
      sounding_ff |-> active_ff)
      else $error("tone driven while no cue is active");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (op_pop && (op_data.kind == OP_STOP)) |=> !active_ff && !sounding_ff)
      else $error("stop transaction left a cue running");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      (!op_pop && !csr_we) |=> $stable(active_ff) && $stable(deadline_ff))
      else $error("cue state changed without a transaction");

endmodule

@@ verif/tone_cue_sequencer_tb.sv @@
`timescale 1ns / 100ps

module tone_cue_sequencer_tb;
   import tcs_pkg::*;

   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam rsp_type    QUIET     = '0;
   localparam int         PHASES    = 10;
   localparam int         PHASE_ITEMS = 125;

   typedef struct {
      bit          reg_write;
      logic        reg_index;
      logic        reg_value;
      logic [1:0]  action;
      logic [4:0]  cue;
      logic [31:0] now_ms;
      bit          typed;
      rsp_type     rsp;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_data  = '0;
   logic    rsp_pop   = 1'b0;
   logic    csr_we    = 1'b0;
   logic    csr_index = 1'b0;
   logic    csr_wdata = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   tone_cue_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cue table: frequency, tone length and trailing gap of every step.
   logic [11:0] rom_hz [0:16][0:2] = '{
      '{1050, 1450, 1950}, '{1850, 0, 0},       '{900, 1200, 0},
      '{1250, 1250, 0},    '{1200, 1750, 0},    '{1000, 1400, 1900},
      '{1550, 0, 0},       '{1200, 1850, 0},    '{1500, 950, 0},
      '{750, 0, 0},        '{1250, 1650, 2150}, '{1800, 1150, 0},
      '{360, 360, 0},      '{1500, 2000, 2500}, '{430, 330, 430},
      '{900, 650, 450},    '{800, 1400, 0}};
   logic [8:0] rom_dur [0:16][0:2] = '{
      '{80, 80, 120},   '{45, 0, 0},      '{100, 150, 0},
      '{100, 150, 0},   '{100, 150, 0},   '{80, 80, 140},
      '{100, 0, 0},     '{100, 160, 0},   '{100, 160, 0},
      '{160, 0, 0},     '{150, 150, 300}, '{140, 220, 0},
      '{160, 200, 0},   '{120, 160, 250}, '{160, 200, 280},
      '{220, 300, 450}, '{100, 180, 0}};
   logic [6:0] rom_gap [0:16][0:2] = '{
      '{30, 30, 0}, '{0, 0, 0},   '{45, 0, 0},
      '{45, 0, 0},  '{45, 0, 0},  '{35, 35, 0},
      '{0, 0, 0},   '{45, 0, 0},  '{45, 0, 0},
      '{0, 0, 0},   '{50, 50, 0}, '{60, 0, 0},
      '{70, 0, 0},  '{40, 40, 0}, '{60, 60, 0},
      '{80, 80, 0}, '{45, 0, 0}};
   int unsigned rom_len [0:16] = '{3, 1, 2, 2, 2, 3, 1, 2, 2, 1, 3, 2, 2, 3, 3, 3, 2};

   bit          cfg_enabled  = 1'b1;
   bit          cfg_attached = 1'b0;
   bit          cue_active;
   logic [4:0]  cue_sel;
   int unsigned step_idx;
   int unsigned step_cnt;
   bit          tone_sounding;
   logic [31:0] deadline;

   rsp_type buzzer_expect_q [$];
   int      mismatch_count = 0;
   bit      steady = 1'b0;

   plan_row_type directed_plan [$] = '{
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd0, 1, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd0, 32'd0, 1, QUIET},
      '{1, REG_ATTACHED, 1, ACT_TICK, 5'd0, 32'd0, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd0, 32'd0, 1, '{1'b1, 12'd1050, 9'd80, 1'b1}},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd79, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd80, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd110, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_SPARE, 5'd31, 32'hFFFF_FFFF, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_STOP, 5'd0, 32'd0, 1, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd17, 32'd200, 1, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd31, 32'd200, 1, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd16, 32'hFFFF_FFF0, 1,
        '{1'b1, 12'd800, 9'd100, 1'b1}},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'h53, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'h54, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'h81, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd1, 32'h7FFF_FFFF, 1,
        '{1'b1, 12'd1850, 9'd45, 1'b1}},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'h8000_002C, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd15, 32'd0, 1, '{1'b1, 12'd900, 9'd220, 1'b1}},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'h8000_0000, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'hFFFF_FFFF, 0, QUIET},
      '{1, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd0, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd15, 32'd0, 1, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd300, 1, QUIET},
      '{1, REG_ENABLED, 1, ACT_TICK, 5'd0, 32'd0, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_PLAY, 5'd13, 32'd0, 1, '{1'b1, 12'd1500, 9'd120, 1'b1}},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd120, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_TICK, 5'd0, 32'd160, 0, QUIET},
      '{0, REG_ENABLED, 0, ACT_STOP, 5'd9, 32'd170, 1, QUIET}};

   function void silence();
      cue_active    = 1'b0;
      cue_sel       = '0;
      step_idx      = 0;
      step_cnt      = 0;
      tone_sounding = 1'b0;
      deadline      = '0;
   endfunction

   function void sound_step(logic [31:0] now);
      if (!cue_active || step_idx >= step_cnt) begin
         silence();
      end else begin
         tone_sounding = 1'b1;
         deadline      = now + rom_dur[cue_sel][step_idx];
      end
   endfunction

   // Deadline reached: the tone gives way to its gap, or a finished gap (or a
   // zero one) moves on to the next step.
   function void advance_phase(logic [31:0] now);
      int unsigned gap_ms;
      if (tone_sounding) begin
         gap_ms        = rom_gap[cue_sel][step_idx];
         tone_sounding = 1'b0;
         if (gap_ms != 0) begin
            deadline = now + gap_ms;
            return;
         end
      end
      step_idx++;
      if (step_idx >= step_cnt)
         silence();
      else
         sound_step(now);
   endfunction

   function rsp_type apply_request(req_type r);
      rsp_type     o;
      logic [31:0] lag;
      case (r.action)
         ACT_PLAY: begin
            if (cfg_attached && cfg_enabled) begin
               silence();
               if (r.cue < CUE_COUNT) begin
                  cue_active = 1'b1;
                  cue_sel    = r.cue;
                  step_cnt   = rom_len[r.cue] > MAX_STEPS ? MAX_STEPS : rom_len[r.cue];
               end
               step_idx = 0;
               sound_step(r.now_ms);
            end
         end
         ACT_STOP: silence();
         ACT_TICK: begin
            lag = r.now_ms - deadline;
            if (cue_active && !lag[31])
               advance_phase(r.now_ms);
         end
         default: ;
      endcase
      o = '0;
      if (tone_sounding) begin
         o.tone_on       = 1'b1;
         o.frequency_hz  = rom_hz[cue_sel][step_idx];
         o.tone_limit_ms = rom_dur[cue_sel][step_idx];
      end
      o.playing = cue_active;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   task automatic check_tone(input rsp_type got);
      rsp_type want;
      if (buzzer_expect_q.size() == 0) begin
         report_mismatch("response with no transaction outstanding");
         return;
      end
      want = buzzer_expect_q.pop_front();
      if (got.tone_on !== want.tone_on)
         report_mismatch($sformatf("tone_on %0b, expected %0b", got.tone_on, want.tone_on));
      if (got.frequency_hz !== want.frequency_hz)
         report_mismatch($sformatf("frequency_hz %0d, expected %0d",
                                   got.frequency_hz, want.frequency_hz));
      if (got.tone_limit_ms !== want.tone_limit_ms)
         report_mismatch($sformatf("tone_limit_ms %0d, expected %0d",
                                   got.tone_limit_ms, want.tone_limit_ms));
      if (got.playing !== want.playing)
         report_mismatch($sformatf("playing %0b, expected %0b", got.playing, want.playing));
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predicted = apply_request(r);
      buzzer_expect_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (buzzer_expect_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic val);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_ENABLED) begin
         cfg_enabled = val;
         if (!val)
            silence();
      end else begin
         cfg_attached = val;
      end
   endtask

   initial begin
      int          stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_tone(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      req_type     req;
      logic [31:0] t_ms;
      int unsigned counted;
      int unsigned sel;
      int          guard;
      bit          en;
      bit          att;
      silence();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].reg_write) begin
            write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            req = '{action: directed_plan[i].action, cue: directed_plan[i].cue,
                    now_ms: directed_plan[i].now_ms};
            send_request(req, directed_plan[i].typed, directed_plan[i].rsp);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            2:       begin en = 1'b0; att = 1'b1; end
            3:       begin en = 1'b1; att = 1'b0; end
            5:       begin en = 1'b0; att = 1'b0; end
            default: begin en = 1'b1; att = 1'b1; end
         endcase
         write_reg(REG_ENABLED, en);
         write_reg(REG_ATTACHED, att);
         steady  = (phase == 4 || phase == 7);
         t_ms    = (phase == 1) ? 32'hFFFF_FE00 : $urandom();
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // Start cues often when silent, seldom in the middle of one.
            sel = $urandom_range(0, 99);
            req.cue = 5'($urandom_range(0, 31));
            if (sel < (cue_active ? 4 : 30)) begin
               req.action = ACT_PLAY;
               if ($urandom_range(0, 9) != 0)
                  req.cue = 5'($urandom_range(0, 16));
            end else if (sel < 34) begin
               req.action = ACT_STOP;
            end else if (sel < 36) begin
               req.action = ACT_SPARE;
            end else begin
               req.action = ACT_TICK;
            end
            if ($urandom_range(0, 49) == 0)
               t_ms = $urandom();
            else
               t_ms = t_ms + $urandom_range(0, 70);
            req.now_ms = t_ms;
            counted++;
            send_request(req, 1'b0, QUIET);
            if ($urandom_range(0, 199) == 0)
               wait_drained();
         end
      end

      req_push <= 1'b0;
      guard = 0;
      while (buzzer_expect_q.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (buzzer_expect_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", buzzer_expect_q.size()));
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
